// ----- sv/ssq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_pkg
// Shared types and constants of the signal aspect lamp sequencer: phase codes,
// per-channel command struct, ASCII codes and the aspect pattern lookup.
// ----------------------------------------------------------------------------
package ssq_pkg;

  localparam int PAIRS     = 4;
  localparam int MSG_BYTES = 2 * PAIRS;

  localparam logic [7:0] LETTER_A   = 8'h61;
  localparam logic [7:0] DIGIT_0    = 8'h30;
  localparam logic [7:0] DIGIT_1    = 8'h31;
  localparam logic [7:0] DIGIT_2    = 8'h32;
  localparam logic [7:0] DIGIT_3    = 8'h33;
  localparam logic [7:0] MAX_LENGTH = 8'd8;

  localparam logic [3:0] PATTERN_RESET = 4'h4;
  localparam logic [3:0] PATTERN_DARK  = 4'h0;
  localparam logic [3:0] MAIN_MASK     = 4'hc;

  localparam logic [0:0] REG_BLANKING    = 1'b0;
  localparam logic [0:0] REG_PROPAGATION = 1'b1;

  localparam logic [15:0] BLANKING_RESET    = 16'd250;
  localparam logic [15:0] PROPAGATION_RESET = 16'd50;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_MAIN = 3'b010,
    PH_FULL = 3'b100
  } phase_t;

  typedef struct packed {
    logic       tick;
    logic       write;
    logic [3:0] pattern;
  } chan_cmd_t;

  function automatic logic [3:0] aspect_pattern(input logic [7:0] digit);
    logic [3:0] pat;
    pat = PATTERN_DARK;
    unique case (digit)
      DIGIT_0: pat = 4'h4;
      DIGIT_1: pat = 4'h8;
      DIGIT_2: pat = 4'ha;
      DIGIT_3: pat = 4'h9;
      default: pat = PATTERN_DARK;
    endcase
    return pat;
  endfunction

endpackage

// ----- sv/ssq_msg_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_msg_decode
// Turns one registered item into a command for every channel: tick flag, or
// pending pattern write from the last valid pair that names the channel.
// ----------------------------------------------------------------------------
module ssq_msg_decode #(
  parameter int CHANNELS = 4
) (
  input  logic               command,
  input  logic [7:0]         msg_length,
  input  logic [7:0]         msg_bytes [ssq_pkg::MSG_BYTES],
  output ssq_pkg::chan_cmd_t cmds      [CHANNELS]
);

  logic                len_ok;
  logic [CHANNELS-1:0] hit   [ssq_pkg::PAIRS];
  logic [3:0]          pat   [ssq_pkg::PAIRS];
  logic [ssq_pkg::PAIRS-1:0] alive;

  always_comb begin
    logic ok;
    len_ok = !msg_length[0] && (msg_length <= ssq_pkg::MAX_LENGTH);
    ok = len_ok;
    for (int p = 0; p < ssq_pkg::PAIRS; p++) begin
      for (int c = 0; c < CHANNELS; c++) begin
        hit[p][c] = (msg_bytes[2*p] == ssq_pkg::LETTER_A + 8'(c));
      end
      pat[p] = ssq_pkg::aspect_pattern(msg_bytes[2*p+1]);
      // a bad letter stops this pair and all later ones
      ok = ok && (|hit[p]);
      alive[p] = ok && (msg_length > 8'(2*p));
    end
    for (int c = 0; c < CHANNELS; c++) begin
      cmds[c].tick    = !command;
      cmds[c].write   = 1'b0;
      cmds[c].pattern = ssq_pkg::PATTERN_DARK;
      for (int p = 0; p < ssq_pkg::PAIRS; p++) begin
        if (command && alive[p] && hit[p][c]) begin
          cmds[c].write   = 1'b1;
          cmds[c].pattern = pat[p];
        end
      end
    end
  end

endmodule

// ----- sv/ssq_channel.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_channel
// State of one signal: pending and shown pattern, phase, due time and lamp
// nibble, updated once per item.
// ----------------------------------------------------------------------------
module ssq_channel (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  ssq_pkg::chan_cmd_t cmd,
  input  logic [31:0]        now_ms,
  input  logic [15:0]        blanking_ms,
  input  logic [15:0]        propagation_ms,
  output logic [3:0]         nibble,
  output logic [3:0]         nibble_next
);

  logic [3:0]      pending, pending_next;
  logic [3:0]      shown, shown_next;
  ssq_pkg::phase_t phase, phase_next;
  logic [31:0]     due, due_next;
  logic            is_due;

  assign is_due = (due == 32'd0) || (due < now_ms);

  always_comb begin
    pending_next = pending;
    shown_next   = shown;
    phase_next   = phase;
    due_next     = due;
    nibble_next  = nibble;
    if (cmd.write) begin
      pending_next = cmd.pattern;
    end
    if (cmd.tick && is_due) begin
      unique case (phase)
        ssq_pkg::PH_MAIN: begin
          nibble_next = nibble | (shown & ssq_pkg::MAIN_MASK);
          phase_next  = ssq_pkg::PH_FULL;
          due_next    = now_ms + {16'd0, propagation_ms};
        end
        ssq_pkg::PH_FULL: begin
          nibble_next = nibble | shown;
          phase_next  = ssq_pkg::PH_IDLE;
          due_next    = 32'd0;
        end
        default: begin
          phase_next = ssq_pkg::PH_IDLE;
          if (pending != shown) begin
            nibble_next = 4'h0;
            shown_next  = pending;
            phase_next  = ssq_pkg::PH_MAIN;
            due_next    = now_ms + {16'd0, blanking_ms};
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= ssq_pkg::PATTERN_RESET;
      shown   <= ssq_pkg::PATTERN_RESET;
      phase   <= ssq_pkg::PH_IDLE;
      due     <= 32'd0;
      nibble  <= ssq_pkg::PATTERN_RESET;
    end else if (step) begin
      pending <= pending_next;
      shown   <= shown_next;
      phase   <= phase_next;
      due     <= due_next;
      nibble  <= nibble_next;
    end
  end

endmodule

// ----- sv/signal_aspect_lamp_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signal_aspect_lamp_sequencer
// Four-lamp signal sequencer: aspect messages and millisecond ticks in, one
// 16-bit lamp word out per item.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle unless a held result stalls it, and returns
// one lamp word per item: the item is captured in an input register, and
// when it advances the per-channel update logic (a 32-bit due-time add and
// compare per channel) writes the channel state and the result register
// together. The result register holds while out_ready is low and the input
// register still takes one more item. Channels above CHANNELS keep their
// nibble at 0x4. The user must write delay registers through cfg_write_en only
// while no item is in flight (not enforced); no clearing pass after reset.
module signal_aspect_lamp_sequencer #(
  parameter int CHANNELS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [31:0] now_ms,
  input  logic [7:0]  msg_length,
  input  logic [7:0]  msg_byte0,
  input  logic [7:0]  msg_byte1,
  input  logic [7:0]  msg_byte2,
  input  logic [7:0]  msg_byte3,
  input  logic [7:0]  msg_byte4,
  input  logic [7:0]  msg_byte5,
  input  logic [7:0]  msg_byte6,
  input  logic [7:0]  msg_byte7,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] lamp_word,
  input  logic        cfg_write_en,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic        s1_valid;
  logic        s1_command;
  logic [31:0] s1_now;
  logic [7:0]  s1_length;
  logic [7:0]  s1_bytes [ssq_pkg::MSG_BYTES];
  logic        advance;
  logic [15:0] blanking_ms;
  logic [15:0] propagation_ms;
  logic [15:0] lamps_cur;
  logic [15:0] lamps_next;

  ssq_pkg::chan_cmd_t cmds [CHANNELS];

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_command  <= command;
      s1_now      <= now_ms;
      s1_length   <= msg_length;
      s1_bytes[0] <= msg_byte0;
      s1_bytes[1] <= msg_byte1;
      s1_bytes[2] <= msg_byte2;
      s1_bytes[3] <= msg_byte3;
      s1_bytes[4] <= msg_byte4;
      s1_bytes[5] <= msg_byte5;
      s1_bytes[6] <= msg_byte6;
      s1_bytes[7] <= msg_byte7;
    end
  end

  // delay registers
  always_ff @(posedge clk) begin
    if (rst) begin
      blanking_ms    <= ssq_pkg::BLANKING_RESET;
      propagation_ms <= ssq_pkg::PROPAGATION_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        ssq_pkg::REG_BLANKING:    blanking_ms    <= cfg_data;
        ssq_pkg::REG_PROPAGATION: propagation_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  ssq_msg_decode #(
    .CHANNELS (CHANNELS)
  ) u_decode (
    .command    (s1_command),
    .msg_length (s1_length),
    .msg_bytes  (s1_bytes),
    .cmds       (cmds)
  );

  for (genvar c = 0; c < 4; c++) begin : g_chan
    if (c < CHANNELS) begin : g_used
      ssq_channel u_channel (
        .clk            (clk),
        .rst            (rst),
        .step           (advance),
        .cmd            (cmds[c]),
        .now_ms         (s1_now),
        .blanking_ms    (blanking_ms),
        .propagation_ms (propagation_ms),
        .nibble         (lamps_cur[4*c +: 4]),
        .nibble_next    (lamps_next[4*c +: 4])
      );
    end else begin : g_unused
      assign lamps_cur[4*c +: 4]  = ssq_pkg::PATTERN_RESET;
      assign lamps_next[4*c +: 4] = ssq_pkg::PATTERN_RESET;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      lamp_word <= lamps_next;
    end
  end

  // a message never changes the lamps
  assert property (@(posedge clk) disable iff (rst)
    advance && s1_command |=> lamp_word == $past(lamps_cur))
    else $error("message changed the lamp word");

  // the result register must not be overwritten while held
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !advance)
    else $error("held result overwritten");

  // a processed item always leaves a result
  assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid && lamp_word == $past(lamps_next))
    else $error("processed item left no result");

  // result register tracks channel state
  assert property (@(posedge clk) disable iff (rst)
    advance |=> lamps_cur == lamp_word)
    else $error("lamp state and result disagree");

endmodule
